FILE: rtl/obcd_pkg.sv
// ----------------------------------------------------------------------------
// obcd_pkg
// Shared widths, constants and types for the oriented box corner distance
// range block.
// ----------------------------------------------------------------------------
package obcd_pkg;

   localparam int CTR_W    = 24;
   localparam int HEAD_W   = 16;
   localparam int EXT_W    = 20;
   localparam int GAP_W    = 24;
   localparam int DIFF_W   = CTR_W + 1;
   localparam int UNIT_W   = 18;
   localparam int UFRAC_W  = 16;

   // unit vector: isqrt of n2 << 32, then (|h| << 32 + mag/2) / mag
   localparam int N2_W     = 2 * HEAD_W;
   localparam int SQ_IN_W  = 2 * N2_W;
   localparam int MAG_W    = SQ_IN_W / 2;
   localparam int DIV_Q_W  = UNIT_W;
   localparam int DIV_N_W  = HEAD_W + 32;
   localparam int UNIT_LAT = 2 + MAG_W + DIV_Q_W;

   localparam logic [UFRAC_W:0] UNIT_ONE = (UFRAC_W + 1)'(1) << UFRAC_W;
   localparam logic [GAP_W-1:0] GAP_MAX  = '1;

   // corner signs, bit k set: minus
   localparam logic [3:0] CORNER_SX_NEG = 4'b0101;
   localparam logic [3:0] CORNER_SY_NEG = 4'b0011;

   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic [EXT_W-1:0]         a_length;
      logic [EXT_W-1:0]         a_width;
      logic [EXT_W-1:0]         b_length;
      logic [EXT_W-1:0]         b_width;
   } side_type;

   typedef struct packed {
      logic [GAP_W-1:0] near_gap;
      logic [GAP_W-1:0] far_gap;
   } gap_type;

endpackage

FILE: rtl/oriented_box_corner_distance_range.sv
// ----------------------------------------------------------------------------
// oriented_box_corner_distance_range
// Largest and smallest excess of box A's corners beyond box B, per box pair.
// ----------------------------------------------------------------------------
// Fully pipelined: one box pair is taken every cycle while no item is parked
// in the skid register. The depth is set mostly by the heading normalization,
// a 32-stage square root followed by an 18-stage divider, plus seven stages
// of projection and corner arithmetic and an output register. A stalled
// output parks one item in a skid register and then holds the pipeline.
module oriented_box_corner_distance_range (
   input  logic         clock,
   input  logic         reset,
   // a_center_x, a_center_y, a_heading_x, a_heading_y, a_length, a_width,
   // b_center_x, b_center_y, b_heading_x, b_heading_y, b_length, b_width
   input  logic [239:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // far_gap, near_gap
   output logic [47:0]  rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready
);
   import obcd_pkg::*;

   logic signed [CTR_W-1:0]  a_center_x, a_center_y, b_center_x, b_center_y;
   logic signed [HEAD_W-1:0] a_heading_x, a_heading_y, b_heading_x, b_heading_y;
   logic [EXT_W-1:0]         a_length, a_width, b_length, b_width;

   logic     en, accept;
   side_type side_in;
   side_type side_ff [UNIT_LAT];

   logic                     ua_valid, ub_valid, c_valid;
   logic signed [UNIT_W-1:0] uax, uay, ubx, uby;
   gap_type                  c_gaps;

   logic    out_valid_ff, skid_valid_ff;
   gap_type out_ff, skid_ff;

   assign a_center_x  = req_tdata[23:0];
   assign a_center_y  = req_tdata[47:24];
   assign a_heading_x = req_tdata[63:48];
   assign a_heading_y = req_tdata[79:64];
   assign a_length    = req_tdata[99:80];
   assign a_width     = req_tdata[119:100];
   assign b_center_x  = req_tdata[143:120];
   assign b_center_y  = req_tdata[167:144];
   assign b_heading_x = req_tdata[183:168];
   assign b_heading_y = req_tdata[199:184];
   assign b_length    = req_tdata[219:200];
   assign b_width     = req_tdata[239:220];

   assign en         = ~skid_valid_ff;
   assign req_tready = en;
   assign accept     = req_tvalid & en;

   assign side_in.dx       = DIFF_W'(a_center_x) - DIFF_W'(b_center_x);
   assign side_in.dy       = DIFF_W'(a_center_y) - DIFF_W'(b_center_y);
   assign side_in.a_length = a_length;
   assign side_in.a_width  = a_width;
   assign side_in.b_length = b_length;
   assign side_in.b_width  = b_width;

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < UNIT_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   obcd_unit u_unit_a (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (accept),
      .hx        (a_heading_x),
      .hy        (a_heading_y),
      .out_valid (ua_valid),
      .ux        (uax),
      .uy        (uay)
   );

   obcd_unit u_unit_b (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (accept),
      .hx        (b_heading_x),
      .hy        (b_heading_y),
      .out_valid (ub_valid),
      .ux        (ubx),
      .uy        (uby)
   );

   obcd_corner u_corner (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (ua_valid & ub_valid),
      .uax       (uax),
      .uay       (uay),
      .ubx       (ubx),
      .uby       (uby),
      .side      (side_ff[UNIT_LAT-1]),
      .out_valid (c_valid),
      .gaps      (c_gaps)
   );

   // output register with skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_tready | ~out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= c_valid;
         end
      end else if (c_valid & en) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_tready | ~out_valid_ff) begin
         out_ff <= skid_valid_ff ? skid_ff : c_gaps;
      end else if (c_valid & en) begin
         skid_ff <= c_gaps;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.near_gap, out_ff.far_gap};

endmodule

FILE: rtl/obcd_isqrt.sv
// ----------------------------------------------------------------------------
// obcd_isqrt
// Pipelined integer square root, one result bit per stage, with a tag that
// travels alongside.
// ----------------------------------------------------------------------------
module obcd_isqrt #(
   parameter int IN_W  = obcd_pkg::SQ_IN_W,
   parameter int TAG_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [IN_W-1:0]   radicand,
   input  logic [TAG_W-1:0]  in_tag,
   output logic              out_valid,
   output logic [IN_W/2-1:0] root,
   output logic [TAG_W-1:0]  out_tag
);

   localparam int OUT_W = IN_W / 2;
   localparam int REM_W = OUT_W + 4;

   logic             valid_ff [OUT_W];
   logic [REM_W-1:0] rem_ff   [OUT_W];
   logic [OUT_W-1:0] root_ff  [OUT_W];
   logic [IN_W-1:0]  rad_ff   [OUT_W];
   logic [TAG_W-1:0] tag_ff   [OUT_W];

   genvar s;
   generate
      for (s = 0; s < OUT_W; s++) begin : g_step
         logic [REM_W-1:0] rem_cur, rem_sh, trial, rem_in;
         logic [OUT_W-1:0] root_cur, root_in;
         logic [IN_W-1:0]  rad_cur;
         logic [TAG_W-1:0] tag_cur;
         logic             v_cur;

         if (s == 0) begin : g_first
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign rad_cur  = radicand;
            assign tag_cur  = in_tag;
            assign v_cur    = in_valid;
         end else begin : g_next
            assign rem_cur  = rem_ff[s-1];
            assign root_cur = root_ff[s-1];
            assign rad_cur  = rad_ff[s-1];
            assign tag_cur  = tag_ff[s-1];
            assign v_cur    = valid_ff[s-1];
         end

         always_comb begin
            rem_sh = {rem_cur[REM_W-3:0], rad_cur[IN_W-1 -: 2]};
            trial  = REM_W'({root_cur, 2'b01});
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_cur[OUT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_cur[OUT_W-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else if (en) begin
               valid_ff[s] <= v_cur;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s]  <= rem_in;
               root_ff[s] <= root_in;
               rad_ff[s]  <= {rad_cur[IN_W-3:0], 2'b00};
               tag_ff[s]  <= tag_cur;
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[OUT_W-1];
   assign root      = root_ff[OUT_W-1];
   assign out_tag   = tag_ff[OUT_W-1];

endmodule

FILE: rtl/obcd_div.sv
// ----------------------------------------------------------------------------
// obcd_div
// Pipelined restoring divider, one quotient bit per stage, with a tag that
// travels alongside. The quotient must fit in Q_W bits.
// ----------------------------------------------------------------------------
module obcd_div #(
   parameter int N_W   = obcd_pkg::DIV_N_W,
   parameter int D_W   = obcd_pkg::MAG_W,
   parameter int Q_W   = obcd_pkg::DIV_Q_W,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [N_W-1:0]   numer,
   input  logic [D_W-1:0]   denom,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [Q_W-1:0]   quot,
   output logic [TAG_W-1:0] out_tag
);

   logic             valid_ff [Q_W];
   logic [D_W-1:0]   rem_ff   [Q_W];
   logic [Q_W-1:0]   lo_ff    [Q_W];
   logic [Q_W-1:0]   quot_ff  [Q_W];
   logic [D_W-1:0]   den_ff   [Q_W];
   logic [TAG_W-1:0] tag_ff   [Q_W];

   genvar s;
   generate
      for (s = 0; s < Q_W; s++) begin : g_step
         logic [D_W-1:0]   rem_cur, den_cur, rem_in;
         logic [D_W:0]     trial;
         logic [Q_W-1:0]   lo_cur, quot_cur;
         logic [TAG_W-1:0] tag_cur;
         logic             v_cur, qbit;

         if (s == 0) begin : g_first
            assign rem_cur  = D_W'(numer[N_W-1:Q_W]);
            assign lo_cur   = numer[Q_W-1:0];
            assign quot_cur = '0;
            assign den_cur  = denom;
            assign tag_cur  = in_tag;
            assign v_cur    = in_valid;
         end else begin : g_next
            assign rem_cur  = rem_ff[s-1];
            assign lo_cur   = lo_ff[s-1];
            assign quot_cur = quot_ff[s-1];
            assign den_cur  = den_ff[s-1];
            assign tag_cur  = tag_ff[s-1];
            assign v_cur    = valid_ff[s-1];
         end

         always_comb begin
            trial = {rem_cur, lo_cur[Q_W-1]};
            qbit  = (trial >= {1'b0, den_cur});
            if (qbit) begin
               rem_in = D_W'(trial - {1'b0, den_cur});
            end else begin
               rem_in = trial[D_W-1:0];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else if (en) begin
               valid_ff[s] <= v_cur;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s]  <= rem_in;
               lo_ff[s]   <= {lo_cur[Q_W-2:0], 1'b0};
               quot_ff[s] <= {quot_cur[Q_W-2:0], qbit};
               den_ff[s]  <= den_cur;
               tag_ff[s]  <= tag_cur;
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[Q_W-1];
   assign quot      = quot_ff[Q_W-1];
   assign out_tag   = tag_ff[Q_W-1];

endmodule

FILE: rtl/obcd_unit.sv
// ----------------------------------------------------------------------------
// obcd_unit
// Heading normalization: magnitude by pipelined square root, components by
// pipelined division, rounded, clamped to one and signed. Zero stays zero.
// ----------------------------------------------------------------------------
module obcd_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic signed [obcd_pkg::HEAD_W-1:0]  hx,
   input  logic signed [obcd_pkg::HEAD_W-1:0]  hy,
   output logic                                out_valid,
   output logic signed [obcd_pkg::UNIT_W-1:0]  ux,
   output logic signed [obcd_pkg::UNIT_W-1:0]  uy
);
   import obcd_pkg::*;

   localparam int SQ_TAG_W = 2 * HEAD_W + 3;

   logic [HEAD_W-1:0] ax, ay;
   logic [HEAD_W-1:0] ax_ff, ay_ff;
   logic [N2_W-1:0]   n2_ff;
   logic              sx_ff, sy_ff, v0_ff;

   logic                sq_valid;
   logic [MAG_W-1:0]    mag;
   logic [SQ_TAG_W-1:0] sq_tag;
   logic [HEAD_W-1:0]   sq_ax, sq_ay;
   logic                sq_sx, sq_sy, sq_zero;
   logic [DIV_N_W-1:0]  numx, numy;

   logic               dx_valid, dy_valid;
   logic [DIV_Q_W-1:0] qx, qy;
   logic [1:0]         dx_tag;
   logic               dy_tag;

   logic [UFRAC_W:0]  cx, cy;
   logic signed [UNIT_W-1:0] ux_in, uy_in, ux_ff, uy_ff;
   logic              v_ff;

   assign ax = hx[HEAD_W-1] ? HEAD_W'(~hx + 1'b1) : hx;
   assign ay = hy[HEAD_W-1] ? HEAD_W'(~hy + 1'b1) : hy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff <= ax;
         ay_ff <= ay;
         sx_ff <= hx[HEAD_W-1];
         sy_ff <= hy[HEAD_W-1];
         n2_ff <= (N2_W'(ax) * N2_W'(ax)) + (N2_W'(ay) * N2_W'(ay));
      end
   end

   obcd_isqrt #(
      .IN_W  (SQ_IN_W),
      .TAG_W (SQ_TAG_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v0_ff),
      .radicand  ({n2_ff, {(SQ_IN_W - N2_W){1'b0}}}),
      .in_tag    ({sx_ff, sy_ff, (n2_ff == '0), ax_ff, ay_ff}),
      .out_valid (sq_valid),
      .root      (mag),
      .out_tag   (sq_tag)
   );

   assign {sq_sx, sq_sy, sq_zero, sq_ax, sq_ay} = sq_tag;
   assign numx = {sq_ax, 32'd0} + DIV_N_W'(mag[MAG_W-1:1]);
   assign numy = {sq_ay, 32'd0} + DIV_N_W'(mag[MAG_W-1:1]);

   obcd_div #(
      .N_W   (DIV_N_W),
      .D_W   (MAG_W),
      .Q_W   (DIV_Q_W),
      .TAG_W (2)
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .numer     (numx),
      .denom     (mag),
      .in_tag    ({sq_sx, sq_zero}),
      .out_valid (dx_valid),
      .quot      (qx),
      .out_tag   (dx_tag)
   );

   obcd_div #(
      .N_W   (DIV_N_W),
      .D_W   (MAG_W),
      .Q_W   (DIV_Q_W),
      .TAG_W (1)
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .numer     (numy),
      .denom     (mag),
      .in_tag    (sq_sy),
      .out_valid (dy_valid),
      .quot      (qy),
      .out_tag   (dy_tag)
   );

   always_comb begin
      cx = (qx > DIV_Q_W'(UNIT_ONE)) ? UNIT_ONE : qx[UFRAC_W:0];
      cy = (qy > DIV_Q_W'(UNIT_ONE)) ? UNIT_ONE : qy[UFRAC_W:0];
      if (dx_tag[0]) begin
         ux_in = '0;
         uy_in = '0;
      end else begin
         ux_in = dx_tag[1] ? -$signed(UNIT_W'(cx)) : $signed(UNIT_W'(cx));
         uy_in = dy_tag ? -$signed(UNIT_W'(cy)) : $signed(UNIT_W'(cy));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= dx_valid & dy_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ux_ff <= ux_in;
         uy_ff <= uy_in;
      end
   end

   assign out_valid = v_ff;
   assign ux        = ux_ff;
   assign uy        = uy_ff;

endmodule

FILE: rtl/obcd_corner.sv
// ----------------------------------------------------------------------------
// obcd_corner
// Projects A's center offset and half-extent vectors on B's axes, builds
// the four corners, their excess beyond B and the largest and smallest.
// ----------------------------------------------------------------------------
module obcd_corner (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic signed [obcd_pkg::UNIT_W-1:0] uax,
   input  logic signed [obcd_pkg::UNIT_W-1:0] uay,
   input  logic signed [obcd_pkg::UNIT_W-1:0] ubx,
   input  logic signed [obcd_pkg::UNIT_W-1:0] uby,
   input  obcd_pkg::side_type                 side,
   output logic                               out_valid,
   output obcd_pkg::gap_type                  gaps
);
   import obcd_pkg::*;

   localparam int LW_W = EXT_W + 1 + UNIT_W;
   localparam int CP_W = DIFF_W + UNIT_W;
   localparam int PR_W = LW_W + UNIT_W;
   localparam int PW   = 62;
   localparam int DW   = PW + 1;
   localparam int SH_W = PW - 32;

   logic [6:0] v_ff;

   // stage 1
   logic signed [LW_W-1:0]   lx_ff, ly_ff, wx_ff, wy_ff;
   logic signed [CP_W-1:0]   cpx_ff, cpy_ff, cqx_ff, cqy_ff;
   logic signed [UNIT_W-1:0] ubx_ff, uby_ff;
   logic [EXT_W-1:0]         bl1_ff, bw1_ff;
   // stage 2
   logic signed [PR_W-1:0]   lpx_ff, lpy_ff, lqx_ff, lqy_ff;
   logic signed [PR_W-1:0]   wpx_ff, wpy_ff, wqx_ff, wqy_ff;
   logic signed [PW-1:0]     pc2_ff, qc2_ff;
   logic [EXT_W-1:0]         bl2_ff, bw2_ff;
   // stage 3
   logic signed [PW-1:0]     pl_ff, ql_ff, pw_ff, qw_ff, pc3_ff, qc3_ff;
   logic [EXT_W-1:0]         bl3_ff, bw3_ff;
   // stages 4..6, one lane per corner
   logic signed [PW-1:0]     p_ff [4];
   logic signed [PW-1:0]     q_ff [4];
   logic signed [DW-1:0]     ep_ff [4];
   logic signed [DW-1:0]     eq_ff [4];
   logic [GAP_W-1:0]         g_ff [4];
   logic [EXT_W-1:0]         bl4_ff, bw4_ff;
   // stage 7
   logic [GAP_W-1:0]         far_in, near_in, far_ff, near_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lx_ff  <= $signed({1'b0, side.a_length}) * uax;
         ly_ff  <= $signed({1'b0, side.a_length}) * uay;
         wx_ff  <= -($signed({1'b0, side.a_width}) * uay);
         wy_ff  <= $signed({1'b0, side.a_width}) * uax;
         cpx_ff <= side.dx * ubx;
         cpy_ff <= side.dy * uby;
         cqx_ff <= side.dx * uby;
         cqy_ff <= side.dy * ubx;
         ubx_ff <= ubx;
         uby_ff <= uby;
         bl1_ff <= side.b_length;
         bw1_ff <= side.b_width;

         lpx_ff <= lx_ff * ubx_ff;
         lpy_ff <= ly_ff * uby_ff;
         lqx_ff <= lx_ff * uby_ff;
         lqy_ff <= ly_ff * ubx_ff;
         wpx_ff <= wx_ff * ubx_ff;
         wpy_ff <= wy_ff * uby_ff;
         wqx_ff <= wx_ff * uby_ff;
         wqy_ff <= wy_ff * ubx_ff;
         pc2_ff <= (PW'(cpx_ff) + PW'(cpy_ff)) <<< 17;
         qc2_ff <= (PW'(cqy_ff) - PW'(cqx_ff)) <<< 17;
         bl2_ff <= bl1_ff;
         bw2_ff <= bw1_ff;

         pl_ff  <= PW'(lpx_ff) + PW'(lpy_ff);
         ql_ff  <= PW'(lqy_ff) - PW'(lqx_ff);
         pw_ff  <= PW'(wpx_ff) + PW'(wpy_ff);
         qw_ff  <= PW'(wqy_ff) - PW'(wqx_ff);
         pc3_ff <= pc2_ff;
         qc3_ff <= qc2_ff;
         bl3_ff <= bl2_ff;
         bw3_ff <= bw2_ff;
         bl4_ff <= bl3_ff;
         bw4_ff <= bw3_ff;
      end
   end

   genvar k;
   generate
      for (k = 0; k < 4; k++) begin : g_lane
         logic signed [PW-1:0] p_in, q_in;
         logic [PW-1:0]        ap, aq, e;
         logic [PW:0]          er;
         logic [SH_W-1:0]      g;

         always_comb begin
            p_in = CORNER_SX_NEG[k] ? (pc3_ff - pl_ff) : (pc3_ff + pl_ff);
            q_in = CORNER_SX_NEG[k] ? (qc3_ff - ql_ff) : (qc3_ff + ql_ff);
            p_in = CORNER_SY_NEG[k] ? (p_in - pw_ff) : (p_in + pw_ff);
            q_in = CORNER_SY_NEG[k] ? (q_in - qw_ff) : (q_in + qw_ff);
         end

         always_comb begin
            ap = p_ff[k][PW-1] ? PW'(-p_ff[k]) : PW'(p_ff[k]);
            aq = q_ff[k][PW-1] ? PW'(-q_ff[k]) : PW'(q_ff[k]);
         end

         always_comb begin
            if (ep_ff[k] > eq_ff[k]) begin
               e = ep_ff[k][DW-1] ? '0 : ep_ff[k][PW-1:0];
            end else begin
               e = eq_ff[k][DW-1] ? '0 : eq_ff[k][PW-1:0];
            end
            er = {1'b0, e} + ((PW + 1)'(1) << 32);
            g  = er[PW:33];
         end

         always_ff @(posedge clock) begin
            if (en) begin
               p_ff[k]  <= p_in;
               q_ff[k]  <= q_in;
               ep_ff[k] <= $signed({1'b0, ap}) - $signed(DW'({bl4_ff, 32'd0}));
               eq_ff[k] <= $signed({1'b0, aq}) - $signed(DW'({bw4_ff, 32'd0}));
               g_ff[k]  <= (g > SH_W'(GAP_MAX)) ? GAP_MAX : g[GAP_W-1:0];
            end
         end
      end
   endgenerate

   always_comb begin
      far_in  = g_ff[0];
      near_in = g_ff[0];
      for (int i = 1; i < 4; i++) begin
         if (g_ff[i] > far_in) begin
            far_in = g_ff[i];
         end
         if (g_ff[i] < near_in) begin
            near_in = g_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         far_ff  <= far_in;
         near_ff <= near_in;
      end
   end

   assign out_valid     = v_ff[6];
   assign gaps.far_gap  = far_ff;
   assign gaps.near_gap = near_ff;

endmodule

FILE: dv/oriented_box_corner_distance_range_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oriented_box_corner_distance_range_test
// Drives box pairs into the block and checks far and near corner gaps
// against an in-bench predictor, with random idling on both sides.
// ----------------------------------------------------------------------------
module oriented_box_corner_distance_range_test;
   import obcd_pkg::*;

   typedef struct packed {
      logic [EXT_W-1:0]  b_width;
      logic [EXT_W-1:0]  b_length;
      logic [HEAD_W-1:0] b_heading_y;
      logic [HEAD_W-1:0] b_heading_x;
      logic [CTR_W-1:0]  b_center_y;
      logic [CTR_W-1:0]  b_center_x;
      logic [EXT_W-1:0]  a_width;
      logic [EXT_W-1:0]  a_length;
      logic [HEAD_W-1:0] a_heading_y;
      logic [HEAD_W-1:0] a_heading_x;
      logic [CTR_W-1:0]  a_center_y;
      logic [CTR_W-1:0]  a_center_x;
   } pair_type;

   typedef struct {
      pair_type   pair;
      bit         known;
      logic [47:0] gaps;
   } row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic [239:0] req_tdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [47:0]  rsp_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;

   logic [47:0]  gap_queue[$];
   int           errors = 0;
   bit           quiet = 1'b0;
   bit           hold_rsp = 1'b0;
   row_type      rows[$];

   oriented_box_corner_distance_range dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [47:0] got,
                                  input logic [47:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic longint unsigned root64(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic void unit_of(input longint hx, input longint hy,
                                   output longint ux, output longint uy);
      longint unsigned ax, ay, n2, mag, qx, qy, one;
      one = 64'(UNIT_ONE);
      ax = hx < 0 ? -hx : hx;
      ay = hy < 0 ? -hy : hy;
      n2 = ax * ax + ay * ay;
      if (n2 == 0) begin
         ux = 0;
         uy = 0;
         return;
      end
      mag = root64(n2 << 32);
      qx = ((ax << 32) + mag / 2) / mag;
      qy = ((ay << 32) + mag / 2) / mag;
      if (qx > one) qx = one;
      if (qy > one) qy = one;
      ux = hx < 0 ? -longint'(qx) : longint'(qx);
      uy = hy < 0 ? -longint'(qy) : longint'(qy);
   endfunction

   function automatic logic [47:0] corner_gaps(input pair_type p);
      longint uax, uay, ubx, uby, dcx, dcy, al, aw, sx, sy, dx, dy, pp, qq;
      longint unsigned hl, hw, ap, aq, e, g, far_g, near_g;
      unit_of(longint'($signed(p.a_heading_x)), longint'($signed(p.a_heading_y)),
              uax, uay);
      unit_of(longint'($signed(p.b_heading_x)), longint'($signed(p.b_heading_y)),
              ubx, uby);
      dcx = (longint'($signed(p.a_center_x)) - longint'($signed(p.b_center_x))) * 131072;
      dcy = (longint'($signed(p.a_center_y)) - longint'($signed(p.b_center_y))) * 131072;
      al = longint'(p.a_length);
      aw = longint'(p.a_width);
      hl = longint'(p.b_length) << 32;
      hw = longint'(p.b_width) << 32;
      far_g = 0;
      near_g = 64'(GAP_MAX);
      for (int k = 0; k < 4; k++) begin
         sx = CORNER_SX_NEG[k] ? -1 : 1;
         sy = CORNER_SY_NEG[k] ? -1 : 1;
         dx = dcx + al * uax * sx - aw * uay * sy;
         dy = dcy + al * uay * sx + aw * uax * sy;
         pp = dx * ubx + dy * uby;
         qq = dy * ubx - dx * uby;
         ap = pp < 0 ? -pp : pp;
         aq = qq < 0 ? -qq : qq;
         e = 0;
         if (ap > hl) e = ap - hl;
         if (aq > hw && aq - hw > e) e = aq - hw;
         g = (e + (64'd1 << 32)) >> 33;
         if (g > 64'(GAP_MAX)) g = 64'(GAP_MAX);
         if (g > far_g) far_g = g;
         if (g < near_g) near_g = g;
      end
      return {near_g[23:0], far_g[23:0]};
   endfunction

   function automatic pair_type random_pair(input int shape);
      pair_type p;
      p = 240'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom});
      if (shape < 6) begin
         // boxes near each other so gaps stay in range
         p.a_center_x = $signed(p.a_center_x) >>> ($urandom_range(4, 12));
         p.a_center_y = $signed(p.a_center_y) >>> ($urandom_range(4, 12));
         p.b_center_x = $signed(p.b_center_x) >>> ($urandom_range(4, 12));
         p.b_center_y = $signed(p.b_center_y) >>> ($urandom_range(4, 12));
         p.a_length >>= $urandom_range(4, 12);
         p.a_width >>= $urandom_range(4, 12);
         p.b_length >>= $urandom_range(4, 12);
         p.b_width >>= $urandom_range(4, 12);
      end
      if (shape == 7) p.a_heading_x = $signed(p.a_heading_x) >>> 14;
      if (shape == 8) p.b_heading_y = '0;
      return p;
   endfunction

   task automatic send_pair(input pair_type p);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tdata <= p;
      req_tvalid <= 1'b1;
      gap_queue.push_back(corner_gaps(p));
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic pair_type make_pair(
      int acx, int acy, int ahx, int ahy, int al, int aw,
      int bcx, int bcy, int bhx, int bhy, int bl, int bw);
      pair_type p;
      p.a_center_x = CTR_W'(acx); p.a_center_y = CTR_W'(acy);
      p.a_heading_x = HEAD_W'(ahx); p.a_heading_y = HEAD_W'(ahy);
      p.a_length = EXT_W'(al); p.a_width = EXT_W'(aw);
      p.b_center_x = CTR_W'(bcx); p.b_center_y = CTR_W'(bcy);
      p.b_heading_x = HEAD_W'(bhx); p.b_heading_y = HEAD_W'(bhy);
      p.b_length = EXT_W'(bl); p.b_width = EXT_W'(bw);
      return p;
   endfunction

   initial begin
      rows.push_back('{make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0});
      // zero B heading: every corner at zero
      rows.push_back('{make_pair(-8388608, 8388607, 32767, -32768, 1048575, 1048575,
                       8388607, -8388608, 0, 0, 0, 0), 1'b1, '0});
      // far apart: saturated
      rows.push_back('{make_pair(-8388608, 0, 1, 0, 0, 0, 8388607, 0, 1, 0, 0, 0),
                       1'b1, {GAP_MAX, GAP_MAX}});
      // A inside B: zero
      rows.push_back('{make_pair(0, 0, 1, 0, 256, 256, 0, 0, 1, 0, 1024, 1024),
                       1'b1, '0});
      // zero A heading, shifted center: all corners at 256
      rows.push_back('{make_pair(512, 0, 0, 0, 1048575, 1048575, 0, 0, 5, 0, 512, 0),
                       1'b1, {24'd256, 24'd256}});
      rows.push_back('{make_pair(100, -200, -32768, -32768, 1048575, 0, 0, 0, 32767,
                       -1, 300, 1048575), 1'b0, '0});
      rows.push_back('{make_pair(0, 0, 0, 1, 2000, 500, 300, 300, -1, 1, 100, 50),
                       1'b0, '0});
      rows.push_back('{make_pair(-5000, 7000, 3, 4, 0, 1048575, 40, 40, 0, -7, 9, 9),
                       1'b0, '0});
      rows.push_back('{make_pair(8388607, 8388607, -1, 0, 1048575, 1048575,
                       8388607, 8388607, 1, 1, 0, 0), 1'b0, '0});
      rows.push_back('{make_pair(1, 2, 32767, 32767, 7, 3, -1, -2, -32768, 1, 1, 1),
                       1'b0, '0});
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) begin
         if (rows[i].known && corner_gaps(rows[i].pair) != rows[i].gaps)
            report_mismatch("predictor row", corner_gaps(rows[i].pair), rows[i].gaps);
         send_pair(rows[i].pair);
      end
      for (int n = 0; n < 1950; n++) begin
         if (n == 600) begin
            req_tvalid <= 1'b0;
            while (gap_queue.size() != 0) @(posedge clock);
            hold_rsp = 1'b1;
         end
         if (n == 1700) quiet = 1'b1;
         send_pair(random_pair($urandom_range(0, 9)));
      end
      req_tvalid <= 1'b0;
      while (gap_queue.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      bit held;
      held = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp && !held) begin
            rsp_tready <= 1'b0;
            repeat (200) @(posedge clock);
            held = 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 3)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (gap_queue.size() == 0) begin
            report_mismatch("unexpected item", rsp_tdata, '0);
         end else begin
            logic [47:0] want;
            want = gap_queue.pop_front();
            if (rsp_tdata[23:0] != want[23:0])
               report_mismatch("far_gap", rsp_tdata, want);
            if (rsp_tdata[47:24] != want[47:24])
               report_mismatch("near_gap", rsp_tdata, want);
         end
      end
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
